// ===== sv/kt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman tracker package
// Shared types, constants, saturation helpers and the sequencer microcode.
// ----------------------------------------------------------------------------
package kt_pkg;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned PC_W   = 7;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic signed [47:0] LIM48 = 48'sh7FFF_FFFF_FFFF;

  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [1:0] REG_INITIAL_COV   = 2'd2;

  localparam logic [15:0] PN_RESET = 16'd128;
  localparam logic [15:0] RN_RESET = 16'd1280;
  localparam logic [23:0] IC_RESET = 24'd256000;

  // Work memory map.
  localparam addr_t A_X   = 6'd16;
  localparam addr_t A_Y   = 6'd17;
  localparam addr_t A_VX  = 6'd18;
  localparam addr_t A_VY  = 6'd19;
  localparam addr_t A_S00 = 6'd20;
  localparam addr_t A_S01 = 6'd21;
  localparam addr_t A_S10 = 6'd22;
  localparam addr_t A_S11 = 6'd23;
  localparam addr_t A_DET = 6'd24;
  localparam addr_t A_K0  = 6'd25;
  localparam addr_t A_K1  = 6'd29;
  localparam addr_t A_Y0  = 6'd33;
  localparam addr_t A_Y1  = 6'd34;
  localparam addr_t A_OLD = 6'd35;
  localparam addr_t A_QX  = 6'd43;
  localparam addr_t A_QY  = 6'd44;

  // Operand sources that are not memory entries.
  localparam addr_t A_SPECIAL = 6'd48;
  localparam addr_t A_ZERO    = 6'd48;
  localparam addr_t A_ONE     = 6'd49;
  localparam addr_t A_DT      = 6'd50;
  localparam addr_t A_ZX      = 6'd51;
  localparam addr_t A_ZY      = 6'd52;
  localparam addr_t A_RN      = 6'd53;
  localparam addr_t A_PN      = 6'd54;
  localparam addr_t A_IC      = 6'd55;

  localparam int unsigned UC_PRED = 0;
  localparam int unsigned UC_UPD  = 22;
  localparam int unsigned UC_INIT = 65;
  localparam int unsigned UC_QRY  = 85;
  localparam int unsigned UC_LEN  = 87;

  typedef struct packed {
    logic [1:0] mode;
    logic [23:0] dt;
    logic [15:0] meas_x;
    logic [15:0] meas_y;
  } kt_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               is_tracking;
  } kt_out_t;

  typedef enum logic {OP_ALU, OP_DIV} op_e;

  // dst = E +/- (A*B +/- C*D), or dst = (A*B +/- C*D) / E for a divide.
  typedef struct packed {
    op_e   op;
    logic  tsub;
    logic  osub;
    logic  sat32;
    logic  last;
    addr_t dst;
    addr_t a;
    addr_t b;
    addr_t c;
    addr_t d;
    addr_t e;
  } uinstr_t;

  typedef struct packed {
    logic              start;
    logic signed [47:0] a;
    logic signed [47:0] b;
  } kt_req_t;

  typedef struct packed {
    logic              done;
    logic signed [47:0] res;
  } kt_rsp_t;

  function automatic logic signed [47:0] sat48(logic signed [48:0] v);
    logic signed [47:0] r;
    begin
      if (v > 49'sh0_7FFF_FFFF_FFFF) begin
        r = LIM48;
      end else if (v < -49'sh0_7FFF_FFFF_FFFF) begin
        r = -LIM48;
      end else begin
        r = v[47:0];
      end
      return r;
    end
  endfunction

  function automatic logic signed [47:0] sat32(logic signed [47:0] v);
    logic signed [47:0] r;
    begin
      if (v > 48'sh0000_7FFF_FFFF) begin
        r = 48'sh0000_7FFF_FFFF;
      end else if (v < -48'sh0000_8000_0000) begin
        r = -48'sh0000_8000_0000;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

  function automatic uinstr_t ucode(logic [PC_W-1:0] pc);
    uinstr_t u;
    int k;
    int m;
    int i;
    int j;
    begin
      u = '0;
      u.op = OP_ALU;
      u.a = A_ZERO;
      u.b = A_ONE;
      u.c = A_ZERO;
      u.d = A_ZERO;
      u.e = A_ZERO;
      k = int'(pc);
      if (k < int'(UC_UPD)) begin
        if (k < 2) begin
          u.dst = addr_t'(int'(A_X) + k);
          u.a = addr_t'(int'(A_VX) + k);
          u.b = A_DT;
          u.e = u.dst;
          u.sat32 = 1'b1;
        end else if (k < 10) begin
          m = k - 2;
          u.dst = addr_t'(m);
          u.a = A_DT;
          u.b = addr_t'(m + 8);
          u.e = u.dst;
        end else if (k < 18) begin
          m = k - 10;
          i = m / 2;
          j = m % 2;
          u.dst = addr_t'(i * 4 + j);
          u.a = A_DT;
          u.b = addr_t'(i * 4 + j + 2);
          u.e = u.dst;
        end else begin
          m = k - 18;
          u.dst = addr_t'(m * 5);
          u.a = A_PN;
          u.e = u.dst;
          u.last = (m == 3);
        end
      end else if (k < int'(UC_INIT)) begin
        m = k - int'(UC_UPD);
        if (m == 0) begin
          u.dst = A_S00;
          u.a = A_RN;
          u.e = 6'd0;
        end else if (m == 1) begin
          u.dst = A_S01;
          u.a = 6'd1;
        end else if (m == 2) begin
          u.dst = A_S10;
          u.a = 6'd4;
        end else if (m == 3) begin
          u.dst = A_S11;
          u.a = A_RN;
          u.e = 6'd5;
        end else if (m == 4) begin
          u.dst = A_DET;
          u.a = A_S00;
          u.b = A_S11;
          u.c = A_S01;
          u.d = A_S10;
          u.tsub = 1'b1;
        end else if (m < 9) begin
          i = m - 5;
          u.op = OP_DIV;
          u.dst = addr_t'(int'(A_K0) + i);
          u.a = addr_t'(4 * i);
          u.b = A_S11;
          u.c = addr_t'(4 * i + 1);
          u.d = A_S10;
          u.tsub = 1'b1;
          u.e = A_DET;
        end else if (m < 13) begin
          i = m - 9;
          u.op = OP_DIV;
          u.dst = addr_t'(int'(A_K1) + i);
          u.a = addr_t'(4 * i + 1);
          u.b = A_S00;
          u.c = addr_t'(4 * i);
          u.d = A_S01;
          u.tsub = 1'b1;
          u.e = A_DET;
        end else if (m < 15) begin
          i = m - 13;
          u.dst = addr_t'(int'(A_Y0) + i);
          u.a = addr_t'(int'(A_X) + i);
          u.e = (i == 0) ? A_ZX : A_ZY;
          u.osub = 1'b1;
        end else if (m < 19) begin
          i = m - 15;
          u.dst = addr_t'(int'(A_X) + i);
          u.a = addr_t'(int'(A_K0) + i);
          u.b = A_Y0;
          u.c = addr_t'(int'(A_K1) + i);
          u.d = A_Y1;
          u.e = u.dst;
          u.sat32 = 1'b1;
        end else if (m < 27) begin
          i = m - 19;
          u.dst = addr_t'(int'(A_OLD) + i);
          u.a = addr_t'(i);
        end else begin
          i = (m - 27) / 4;
          j = (m - 27) % 4;
          u.dst = addr_t'(m - 27);
          u.a = addr_t'(int'(A_K0) + i);
          u.b = addr_t'(int'(A_OLD) + j);
          u.c = addr_t'(int'(A_K1) + i);
          u.d = addr_t'(int'(A_OLD) + 4 + j);
          u.e = u.dst;
          u.osub = 1'b1;
          u.last = (m == 42);
        end
      end else if (k < int'(UC_QRY)) begin
        m = k - int'(UC_INIT);
        if (m < 2) begin
          u.dst = addr_t'(int'(A_X) + m);
          u.a = (m == 0) ? A_ZX : A_ZY;
        end else if (m < 4) begin
          u.dst = addr_t'(int'(A_X) + m);
        end else begin
          i = m - 4;
          u.dst = addr_t'(i);
          u.a = ((i % 5) == 0) ? A_IC : A_ZERO;
          u.last = (m == 19);
        end
      end else begin
        m = k - int'(UC_QRY);
        u.dst = addr_t'(int'(A_QX) + m);
        u.a = addr_t'(int'(A_VX) + m);
        u.b = A_DT;
        u.e = addr_t'(int'(A_X) + m);
        u.sat32 = 1'b1;
        u.last = (m == 1);
      end
      return u;
    end
  endfunction

endpackage

// ===== sv/kt_mulq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman tracker fixed-point multiplier
// Q.16 product of two 48-bit values built from four 24x24 partial products,
// truncated toward zero and saturated to the 48-bit range.
// ----------------------------------------------------------------------------
module kt_mulq import kt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  kt_req_t req_i,
  output kt_rsp_t rsp_o
);

  logic        busy_q, fin_q, done_q, neg_q;
  logic [1:0]  cnt_q;
  logic [47:0] ma_q, mb_q;
  logic [95:0] acc_q;
  logic signed [47:0] p_q;
  logic [23:0] ah, bh;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  logic signed [47:0] r;

  assign ah = cnt_q[1] ? ma_q[47:24] : ma_q[23:0];
  assign bh = cnt_q[0] ? mb_q[47:24] : mb_q[23:0];
  assign pp = ah * bh;

  always_comb begin
    case (cnt_q)
      2'd0: pp_sh = {48'd0, pp};
      2'd3: pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  assign r = (|acc_q[95:63]) ? LIM48 : $signed({1'b0, acc_q[62:16]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[47] ^ req_i.b[47];
      ma_q  <= req_i.a[47] ? 48'(-req_i.a) : req_i.a;
      mb_q  <= req_i.b[47] ? 48'(-req_i.b) : req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      p_q <= neg_q ? -r : r;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = p_q;

endmodule

// ===== sv/kt_divq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman tracker fixed-point divider
// Restoring divider, one quotient bit per cycle, giving (|n| << 16) / |d|
// with sign and saturation; a zero divisor saturates at once unless n is zero.
// ----------------------------------------------------------------------------
module kt_divq import kt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  kt_req_t req_i,
  output kt_rsp_t rsp_o
);

  logic        busy_q, fin_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [47:0] ud_q, rem_q;
  logic [62:0] dvd_q;
  logic signed [47:0] q_q;
  logic [47:0] un, ud;
  logic [49:0] trial;
  logic        ge;
  logic signed [47:0] qs;

  assign un = req_i.a[47] ? 48'(-req_i.a) : req_i.a;
  assign ud = req_i.b[47] ? 48'(-req_i.b) : req_i.b;
  assign trial = {1'b0, rem_q, dvd_q[62]} - {2'b00, ud_q};
  assign ge = !trial[49];
  assign qs = (|dvd_q[62:47]) ? LIM48 : $signed({1'b0, dvd_q[46:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        cnt_q <= 6'd0;
        if (ud == 48'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd62) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[47] ^ req_i.b[47];
      ud_q  <= ud;
      rem_q <= '0;
      dvd_q <= {(un[47] ? 47'h7FFF_FFFF_FFFF : un[46:0]), 16'd0};
      if (req_i.a == 48'sd0) begin
        q_q <= '0;
      end else begin
        q_q <= req_i.a[47] ? -LIM48 : LIM48;
      end
    end else if (busy_q) begin
      rem_q <= ge ? trial[47:0] : {rem_q[46:0], dvd_q[62]};
      dvd_q <= {dvd_q[61:0], ge};
    end else if (fin_q) begin
      q_q <= neg_q ? -qs : qs;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = q_q;

endmodule

// ===== sv/kalman_tracker_2d_const_velocity_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman tracker, 2D constant velocity
// Channel   Direction  Payload   Handshake
// cfg       in         24 bits   cfg_we_i, no wait
// in        in         kt_in_t   in_valid_i / in_stall_o
// out       out        kt_out_t  out_valid_o / out_stall_i
// An update includes the eight gain divisions of the restoring divider.
// Every micro-instruction reads its five operands through the single read
// port of the work memory, then uses the shared multiplier twice.
// No clearing after reset is needed. A new transaction is taken while a
// result is stalled.
// ----------------------------------------------------------------------------
module kalman_tracker_2d_const_velocity_unit import kt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  kt_in_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output kt_out_t     out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL1, S_MUL2, S_COMB, S_DIV, S_WR, S_ORD, S_OUT
  } state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic [2:0]      cnt_q;
  logic            started_q;
  logic [15:0]     pn_q, rn_q;
  logic [23:0]     ic_q;
  kt_in_t          in_q;
  logic signed [47:0] opnd_q [5];
  logic signed [47:0] p1_q, t_q, res_q;
  logic [31:0]     ores_q [4];
  addr_t           raddr_q;
  logic signed [47:0] mem_q;
  logic signed [47:0] mem [64];
  logic            out_valid_q;
  kt_out_t         out_data_q;

  uinstr_t         ui;
  addr_t           rd_addr;
  logic signed [47:0] rd_val;
  logic            qry;
  kt_req_t         mul_req, div_req;
  kt_rsp_t         mul_rsp, div_rsp;
  logic signed [48:0] tsum, osum;
  logic signed [47:0] ores;
  logic            out_free;

  assign ui  = ucode(pc_q);
  assign qry = (in_q.mode == MODE_QUERY) && started_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rd_addr = ui.e;
    if (state_q == S_ORD) begin
      case (cnt_q)
        3'd0: rd_addr = qry ? A_QX : A_X;
        3'd1: rd_addr = qry ? A_QY : A_Y;
        3'd2: rd_addr = A_VX;
        default: rd_addr = A_VY;
      endcase
    end else begin
      case (cnt_q)
        3'd0: rd_addr = ui.a;
        3'd1: rd_addr = ui.b;
        3'd2: rd_addr = ui.c;
        3'd3: rd_addr = ui.d;
        default: rd_addr = ui.e;
      endcase
    end
  end

  always_comb begin
    if (raddr_q >= A_SPECIAL) begin
      case (raddr_q)
        A_ONE: rd_val = 48'sd65536;
        A_DT:  rd_val = $signed({24'd0, in_q.dt});
        A_ZX:  rd_val = $signed({20'd0, in_q.meas_x, 12'd0});
        A_ZY:  rd_val = $signed({20'd0, in_q.meas_y, 12'd0});
        A_RN:  rd_val = $signed({24'd0, rn_q, 8'd0});
        A_PN:  rd_val = $signed({24'd0, pn_q, 8'd0});
        A_IC:  rd_val = $signed({16'd0, ic_q, 8'd0});
        default: rd_val = '0;
      endcase
    end else begin
      rd_val = mem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_q   <= mem[rd_addr];
    raddr_q <= rd_addr;
    if (state_q == S_WR) begin
      mem[ui.dst] <= res_q;
    end
  end

  assign mul_req.start = ((state_q == S_RD) && (cnt_q == 3'd5)) ||
                         ((state_q == S_MUL1) && mul_rsp.done);
  assign mul_req.a = (state_q == S_RD) ? opnd_q[0] : opnd_q[2];
  assign mul_req.b = (state_q == S_RD) ? opnd_q[1] : opnd_q[3];

  assign div_req.start = (state_q == S_COMB) && (ui.op == OP_DIV);
  assign div_req.a = t_q;
  assign div_req.b = opnd_q[4];

  kt_mulq u_mulq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  kt_divq u_divq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign tsum = ui.tsub ? ({p1_q[47], p1_q} - {mul_rsp.res[47], mul_rsp.res})
                        : ({p1_q[47], p1_q} + {mul_rsp.res[47], mul_rsp.res});
  assign osum = ui.osub ? ({opnd_q[4][47], opnd_q[4]} - {t_q[47], t_q})
                        : ({opnd_q[4][47], opnd_q[4]} + {t_q[47], t_q});
  assign ores = ui.sat32 ? sat32(sat48(osum)) : sat48(osum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      pn_q        <= PN_RESET;
      rn_q        <= RN_RESET;
      ic_q        <= IC_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PROCESS_NOISE: pn_q <= cfg_wdata_i[15:0];
          REG_MEASURE_NOISE: rn_q <= cfg_wdata_i[15:0];
          REG_INITIAL_COV:   ic_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= S_RD;
            if (in_data_i.mode == MODE_UPDATE) begin
              pc_q <= started_q ? PC_W'(UC_UPD) : PC_W'(UC_INIT);
            end else if (in_data_i.mode == MODE_PREDICT && started_q) begin
              pc_q <= PC_W'(UC_PRED);
            end else if (in_data_i.mode == MODE_QUERY && started_q) begin
              pc_q <= PC_W'(UC_QRY);
            end else begin
              state_q <= S_ORD;
            end
          end
        end
        S_RD: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd5) begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_rsp.done) begin
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_rsp.done) begin
            state_q <= S_COMB;
          end
        end
        S_COMB: begin
          state_q <= (ui.op == OP_DIV) ? S_DIV : S_WR;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          cnt_q <= '0;
          if (ui.last) begin
            state_q <= S_ORD;
            if (in_q.mode == MODE_UPDATE) begin
              started_q <= 1'b1;
            end
          end else begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= S_RD;
          end
        end
        S_ORD: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_RD && cnt_q != 3'd0) begin
      opnd_q[cnt_q - 3'd1] <= rd_val;
    end
    if (state_q == S_MUL1 && mul_rsp.done) begin
      p1_q <= mul_rsp.res;
    end
    if (state_q == S_MUL2 && mul_rsp.done) begin
      t_q <= sat48(tsum);
    end
    if (state_q == S_COMB) begin
      res_q <= ores;
    end
    if (state_q == S_DIV && div_rsp.done) begin
      res_q <= div_rsp.res;
    end
    if (state_q == S_ORD && cnt_q != 3'd0) begin
      ores_q[cnt_q[1:0] - 2'd1] <= started_q ? rd_val[31:0] : 32'd0;
    end
    if (state_q == S_OUT && out_free) begin
      out_data_q.pos_x       <= $signed(ores_q[0]);
      out_data_q.pos_y       <= $signed(ores_q[1]);
      out_data_q.vel_x       <= $signed(ores_q[2]);
      out_data_q.vel_y       <= $signed(ores_q[3]);
      out_data_q.is_tracking <= started_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_WR) |-> (int'(pc_q) < int'(UC_LEN)))
    else $error("microcode address out of range");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(started_q))
    else $error("tracking flag cleared");

  a_unit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_req.start && div_req.start))
    else $error("multiplier and divider started together");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded into a free output register");

endmodule
